// File: sv/bpfa_pkg.sv
// bpfa_pkg: shared types and constants of the bitmap page frame allocator
// depends on nothing; imported by bpfa_mem, bitmap_page_frame_allocator and tb_bitmap_page_frame_allocator
`default_nettype none
package bpfa_pkg;

    // bitmap word width, one bit per page
    localparam int unsigned WORD_BITS = 64;

    // operation codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_INIT = 7'b0000001,
        ST_IDLE = 7'b0000010,
        ST_MRD  = 7'b0000100,
        ST_MWR  = 7'b0001000,
        ST_SRD  = 7'b0010000,
        ST_SDAT = 7'b0100000,
        ST_SBIT = 7'b1000000
    } t_state;

    // memory control: write enable and read enable
    typedef struct packed {
        logic       we;
        logic       re;
    } t_mem_ctl;

endpackage
`default_nettype wire

// File: sv/bpfa_mem.sv
// bpfa_mem: single-port-write, single-port-read bitmap word memory
// registered read; uses bpfa_pkg for word width and control struct
`default_nettype none
module bpfa_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire                            i_clk,
    input  wire  bpfa_pkg::t_mem_ctl       i_ctl,
    input  wire  [AW-1:0]                  i_waddr,
    input  wire  [bpfa_pkg::WORD_BITS-1:0] i_wdata,
    input  wire  [AW-1:0]                  i_raddr,
    output logic [bpfa_pkg::WORD_BITS-1:0] o_rdata
);
    import bpfa_pkg::*;

    logic [WORD_BITS-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: sv/bitmap_page_frame_allocator.sv
// bitmap_page_frame_allocator: first-fit page allocator over a used/free bitmap
// depends on bpfa_pkg and bpfa_mem
//
// Accepts one command (allocate, free range, reserve range) when start is high
// and busy is low, and gives exactly one result beat on o_valid, which cannot
// be held off. After reset a clearing pass writes PAGE_COUNT/64 (rounded up)
// words to mark every page used; busy stays high meanwhile. Free and reserve
// read and rewrite each bitmap word touched, then run a refresh scan of the
// lowest free run. The scans go through the single bitmap memory: a word that
// is fully used or fully free is judged whole, and a mixed word is walked one
// bit per cycle. Allocate is a scan to the first fitting run, the marking of
// that run and a refresh scan, so its latency grows with fragmentation.
`default_nettype none
module bitmap_page_frame_allocator #(
    parameter int unsigned PAGE_COUNT = 65536
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_opcode,
    input  wire  [15:0] i_start_page,
    input  wire  [16:0] i_num_pages,
    output logic        o_valid,
    output logic [15:0] o_alloc_page,
    output logic        o_ok
);
    import bpfa_pkg::*;

    localparam int unsigned WORDS = (PAGE_COUNT + 63) / 64;
    localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned PW    = WW + 6;
    localparam int unsigned LW    = PW + 1;
    localparam int unsigned EW    = (LW > 18) ? LW : 18;

    t_state           r_state, n_state;
    logic [WW-1:0]    r_w, n_w;
    logic [5:0]       r_b, n_b;
    logic [LW-1:0]    r_rl, n_rl;
    logic [PW-1:0]    r_rs, n_rs;
    logic [PW-1:0]    r_lo, n_lo;
    logic [PW-1:0]    r_hi, n_hi;
    logic             r_set, n_set;
    logic             r_amode, n_amode;
    logic [16:0]      r_n, n_n;
    logic             r_len_nz, n_len_nz;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic             n_valid;
    logic [15:0]      n_page;
    logic             n_ok;

    t_mem_ctl             mem_ctl;
    logic [WW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;

    bpfa_mem #(.DEPTH(WORDS), .AW(WW)) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_w),
        .o_rdata (mem_rdata)
    );

    // pages past the end read as used
    logic [WORD_BITS-1:0] past_mask;
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            past_mask[b] = ({1'b0, r_w, 6'(b)} >= LW'(PAGE_COUNT));
        end
    end

    // range mask for the word being marked
    logic [5:0]           lo_b, hi_b;
    logic [WORD_BITS-1:0] rmask;
    always_comb begin
        lo_b  = (r_w == r_lo[PW-1:6]) ? r_lo[5:0] : 6'd0;
        hi_b  = (r_w == r_hi[PW-1:6]) ? r_hi[5:0] : 6'd63;
        rmask = ({WORD_BITS{1'b1}} << lo_b) & ({WORD_BITS{1'b1}} >> (6'd63 - hi_b));
    end

    // range decode of a free or reserve command
    logic [EW-1:0] cmd_sum, cmd_end;
    logic          cmd_empty;
    always_comb begin
        cmd_sum   = EW'(i_start_page) + EW'(i_num_pages);
        cmd_end   = (cmd_sum > EW'(PAGE_COUNT)) ? EW'(PAGE_COUNT) : cmd_sum;
        cmd_empty = (EW'(i_start_page) >= cmd_end);
    end

    logic [WORD_BITS-1:0] scan_word;
    logic [LW:0]          rl_plus64;
    logic [PW-1:0]        bit_page, run_start, word_page;
    logic                 last_word;

    always_comb begin
        scan_word = mem_rdata | past_mask;
        rl_plus64 = {1'b0, r_rl} + (LW+1)'(WORD_BITS);
        bit_page  = {r_w, r_b};
        word_page = {r_w, 6'd0};
        last_word = (r_w == WW'(WORDS - 1));
        run_start = r_rs;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_w      = r_w;
        n_b      = r_b;
        n_rl     = r_rl;
        n_rs     = r_rs;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_set    = r_set;
        n_amode  = r_amode;
        n_n      = r_n;
        n_len_nz = r_len_nz;
        n_word   = r_word;
        n_valid  = 1'b0;
        n_page   = o_alloc_page;
        n_ok     = o_ok;
        mem_ctl  = '0;
        mem_waddr = r_w;
        mem_wdata = {WORD_BITS{1'b1}};
        case (r_state)
            ST_INIT: begin
                mem_ctl.we = 1'b1;
                if (last_word) begin
                    n_state = ST_IDLE;
                    n_w     = '0;
                end else begin
                    n_w = r_w + 1'b1;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_page = 16'd0;
                    n_ok   = 1'b0;
                    n_n    = i_num_pages;
                    case (i_opcode)
                        OP_ALLOC: begin
                            if (i_num_pages == 17'd0 ||
                                EW'(i_num_pages) > EW'(PAGE_COUNT) || !r_len_nz) begin
                                n_valid = 1'b1;
                            end else begin
                                n_amode = 1'b1;
                                n_w     = '0;
                                n_rl    = '0;
                                n_state = ST_SRD;
                            end
                        end
                        OP_FREE, OP_RESERVE: begin
                            n_ok = 1'b1;
                            if (cmd_empty) begin
                                n_valid = 1'b1;
                            end else begin
                                n_set   = (i_opcode == OP_RESERVE);
                                n_lo    = PW'(i_start_page);
                                n_hi    = PW'(cmd_end - 1'b1);
                                n_w     = WW'(i_start_page >> 6);
                                n_state = ST_MRD;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_MRD: begin
                mem_ctl.re = 1'b1;
                n_state    = ST_MWR;
            end
            ST_MWR: begin
                mem_ctl.we = 1'b1;
                mem_wdata  = r_set ? (mem_rdata | rmask) : (mem_rdata & ~rmask);
                if (r_w == r_hi[PW-1:6]) begin
                    n_amode = 1'b0;
                    n_w     = '0;
                    n_rl    = '0;
                    n_state = ST_SRD;
                end else begin
                    n_w     = r_w + 1'b1;
                    n_state = ST_MRD;
                end
            end
            ST_SRD: begin
                mem_ctl.re = 1'b1;
                n_state    = ST_SDAT;
            end
            ST_SDAT: begin
                if (scan_word == {WORD_BITS{1'b1}}) begin
                    // fully used word ends any run
                    n_rl = '0;
                    if ((!r_amode && r_rl != '0) || last_word) begin
                        n_state = ST_IDLE;
                        n_valid = 1'b1;
                        if (!r_amode) n_len_nz = (17'(r_rl) != 17'd0);
                    end else begin
                        n_w     = r_w + 1'b1;
                        n_state = ST_SRD;
                    end
                end else if (scan_word == '0) begin
                    // fully free word extends the run
                    if (r_rl == '0) n_rs = word_page;
                    if (r_amode && rl_plus64 >= (LW+1)'(r_n)) begin
                        n_lo    = (r_rl == '0) ? word_page : run_start;
                        n_hi    = PW'(((r_rl == '0) ? word_page : run_start) + PW'(r_n) - 1'b1);
                        n_page  = 16'((r_rl == '0) ? word_page : run_start);
                        n_ok    = 1'b1;
                        n_set   = 1'b1;
                        n_w     = ((r_rl == '0) ? word_page[PW-1:6] : run_start[PW-1:6]);
                        n_state = ST_MRD;
                    end else begin
                        n_rl = rl_plus64[LW-1:0];
                        if (last_word) begin
                            n_state = ST_IDLE;
                            n_valid = 1'b1;
                            if (!r_amode) n_len_nz = (17'(rl_plus64) != 17'd0);
                        end else begin
                            n_w     = r_w + 1'b1;
                            n_state = ST_SRD;
                        end
                    end
                end else begin
                    n_word  = scan_word;
                    n_b     = 6'd0;
                    n_state = ST_SBIT;
                end
            end
            ST_SBIT: begin
                if (!r_word[r_b]) begin
                    // free page
                    if (r_rl == '0) n_rs = bit_page;
                    n_rl = r_rl + 1'b1;
                    if (r_amode && (r_rl + 1'b1) == LW'(r_n)) begin
                        n_lo    = (r_rl == '0) ? bit_page : run_start;
                        n_hi    = PW'(((r_rl == '0) ? bit_page : run_start) + PW'(r_n) - 1'b1);
                        n_page  = 16'((r_rl == '0) ? bit_page : run_start);
                        n_ok    = 1'b1;
                        n_set   = 1'b1;
                        n_w     = ((r_rl == '0) ? bit_page[PW-1:6] : run_start[PW-1:6]);
                        n_state = ST_MRD;
                    end else if (r_b == 6'd63) begin
                        if (last_word) begin
                            n_state = ST_IDLE;
                            n_valid = 1'b1;
                            if (!r_amode) n_len_nz = ((17'(r_rl) + 17'd1) != 17'd0);
                        end else begin
                            n_w     = r_w + 1'b1;
                            n_state = ST_SRD;
                        end
                    end else begin
                        n_b = r_b + 1'b1;
                    end
                end else begin
                    // used page ends the run
                    n_rl = '0;
                    if ((!r_amode && r_rl != '0) || (r_b == 6'd63 && last_word)) begin
                        n_state = ST_IDLE;
                        n_valid = 1'b1;
                        if (!r_amode) n_len_nz = (17'(r_rl) != 17'd0);
                    end else if (r_b == 6'd63) begin
                        n_w     = r_w + 1'b1;
                        n_state = ST_SRD;
                    end else begin
                        n_b = r_b + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_w      <= '0;
            r_len_nz <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_w      <= n_w;
            r_len_nz <= n_len_nz;
            o_valid  <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_b          <= n_b;
        r_rl         <= n_rl;
        r_rs         <= n_rs;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_set        <= n_set;
        r_amode      <= n_amode;
        r_n          <= n_n;
        r_word       <= n_word;
        o_alloc_page <= n_page;
        o_ok         <= n_ok;
    end

    assign busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

// File: sim/tb_bitmap_page_frame_allocator.sv
// tb_bitmap_page_frame_allocator: self-checking bench for the first-fit page allocator
// depends on bpfa_pkg and bitmap_page_frame_allocator; runs a directed table then random beats
`timescale 1ns / 100ps
`default_nettype none
module tb_bitmap_page_frame_allocator;
    import bpfa_pkg::*;

    localparam int unsigned PAGES      = 65536;
    localparam int unsigned WORDS      = PAGES / 64;
    localparam logic [1:0]  OP_UNKNOWN = 2'd3;
    localparam int unsigned N_RANDOM   = 1400;
    localparam int unsigned N_CALM     = 200;
    localparam longint      CYCLE_CAP  = 64'd60_000_000;
    localparam int unsigned DRAIN_CAP  = 2_000_000;

    typedef struct {
        logic [15:0] page;
        logic        ok;
    } t_alloc_result;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] first;
        logic [16:0] count;
        bit          typed;
        logic [15:0] page;
        logic        ok;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    wire         busy;
    logic [1:0]  i_opcode;
    logic [15:0] i_start_page;
    logic [16:0] i_num_pages;
    wire         o_valid;
    wire  [15:0] o_alloc_page;
    wire         o_ok;

    bit   [63:0]   frame_map [WORDS];
    t_alloc_result pending_results[$];
    int unsigned   error_count;
    longint        cycle_count;

    bitmap_page_frame_allocator #(.PAGE_COUNT(PAGES)) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_start_page (i_start_page),
        .i_num_pages  (i_num_pages),
        .o_valid      (o_valid),
        .o_alloc_page (o_alloc_page),
        .o_ok         (o_ok)
    );

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("bitmap_page_frame_allocator verification failed");
            $finish;
        end
    end

    // pages past the end count as used
    function automatic bit page_used(int unsigned p);
        if (p >= PAGES) return 1'b1;
        return frame_map[p >> 6][p & 63];
    endfunction

    function automatic void mark_pages(int unsigned first, int unsigned count, bit used);
        int unsigned last;
        last = first + count;
        if (last > PAGES) last = PAGES;
        for (int unsigned p = first; p < last; p++) frame_map[p >> 6][p & 63] = used;
    endfunction

    // lowest start of a free run of n pages, PAGES if none
    function automatic int unsigned first_fit(int unsigned n);
        int unsigned p;
        int unsigned run;
        p = 0;
        while (p < PAGES) begin
            if ((p & 63) == 0 && frame_map[p >> 6] == '1) begin
                p += 64;
                continue;
            end
            if (page_used(p)) begin
                p++;
                continue;
            end
            run = 0;
            while (run < n && !page_used(p + run)) run++;
            if (run == n) return p;
            p += run;
        end
        return PAGES;
    endfunction

    // apply one command to the shadow bitmap and return its result
    function automatic t_alloc_result predict_command(logic [1:0] op, logic [15:0] first,
                                                     logic [16:0] count);
        t_alloc_result r;
        int unsigned   p;
        r.page = '0;
        r.ok   = 1'b0;
        case (op)
            OP_ALLOC: begin
                if (count != 0 && count <= PAGES) begin
                    p = first_fit(count);
                    if (p < PAGES) begin
                        mark_pages(p, count, 1'b1);
                        r.page = p[15:0];
                        r.ok   = 1'b1;
                    end
                end
            end
            OP_FREE: begin
                mark_pages(first, count, 1'b0);
                r.ok = 1'b1;
            end
            OP_RESERVE: begin
                mark_pages(first, count, 1'b1);
                r.ok = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // present one beat, wait for acceptance, queue its expected result
    task automatic issue_command(logic [1:0] op, logic [15:0] first, logic [16:0] count,
                                 bit typed, logic [15:0] page, logic ok);
        t_alloc_result r;
        @(negedge i_clk);
        start        <= 1'b1;
        i_opcode     <= op;
        i_start_page <= first;
        i_num_pages  <= count;
        do @(posedge i_clk); while (busy);
        r = predict_command(op, first, count);
        if (typed) begin
            r.page = page;
            r.ok   = ok;
        end
        pending_results.push_back(r);
    endtask

    // sender gap: start low for a burst of cycles
    task automatic idle_burst(int unsigned n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result page=%0d ok=%0b", $time, o_alloc_page, o_ok);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_alloc_page !== want.page) begin
                    $display("%0t: alloc_page expected %0d actual %0d",
                             $time, want.page, o_alloc_page);
                    error_count++;
                end
                if (o_ok !== want.ok) begin
                    $display("%0t: ok expected %0b actual %0b", $time, want.ok, o_ok);
                    error_count++;
                end
            end
        end
    end

    t_stim_row directed [] = '{
        // after reset nothing is free
        '{OP_ALLOC,   16'd0,     17'd1,      1, 16'd0,     1'b0},
        '{OP_ALLOC,   16'd0,     17'd0,      1, 16'd0,     1'b0},
        '{OP_FREE,    16'd0,     17'd0,      1, 16'd0,     1'b1},
        '{OP_UNKNOWN, 16'hffff,  17'h1ffff,  1, 16'd0,     1'b0},
        '{OP_FREE,    16'd0,     17'd65536,  1, 16'd0,     1'b1},
        '{OP_ALLOC,   16'd0,     17'd65536,  1, 16'd0,     1'b1},
        '{OP_ALLOC,   16'd0,     17'd1,      1, 16'd0,     1'b0},
        '{OP_FREE,    16'd0,     17'h1ffff,  1, 16'd0,     1'b1},
        '{OP_ALLOC,   16'd0,     17'd65537,  1, 16'd0,     1'b0},
        '{OP_RESERVE, 16'd0,     17'h1ffff,  1, 16'd0,     1'b1},
        '{OP_FREE,    16'hffff,  17'd5,      1, 16'd0,     1'b1},
        '{OP_ALLOC,   16'd0,     17'd2,      1, 16'd0,     1'b0},
        '{OP_ALLOC,   16'd0,     17'd1,      1, 16'hffff,  1'b1},
        '{OP_FREE,    16'd100,   17'd10,     1, 16'd0,     1'b1},
        '{OP_ALLOC,   16'd0,     17'd4,      1, 16'd100,   1'b1},
        '{OP_FREE,    16'd200,   17'd3,      0, 16'd0,     1'b0},
        '{OP_ALLOC,   16'd0,     17'd7,      0, 16'd0,     1'b0},
        '{OP_ALLOC,   16'd0,     17'd6,      0, 16'd0,     1'b0},
        '{OP_ALLOC,   16'd0,     17'd3,      0, 16'd0,     1'b0},
        '{OP_FREE,    16'd63,    17'd66,     0, 16'd0,     1'b0},
        '{OP_ALLOC,   16'd0,     17'd66,     0, 16'd0,     1'b0},
        '{OP_RESERVE, 16'd64,    17'd0,      1, 16'd0,     1'b1},
        '{OP_RESERVE, 16'd0,     17'd65536,  1, 16'd0,     1'b1}
    };

    initial begin
        logic [1:0]  op;
        logic [15:0] first;
        logic [16:0] count;
        int unsigned pick;
        int unsigned waited;

        error_count  = 0;
        cycle_count  = 0;
        start        = 1'b0;
        i_opcode     = OP_ALLOC;
        i_start_page = '0;
        i_num_pages  = '0;
        i_rst_n      = 1'b0;
        foreach (frame_map[w]) frame_map[w] = '1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed[i]) begin
            issue_command(directed[i].op, directed[i].first, directed[i].count,
                          directed[i].typed, directed[i].page, directed[i].ok);
            if ($urandom_range(0, 2) == 0) idle_burst($urandom_range(1, 13));
        end

        // random beats, mostly confined to the low pages to keep scans short
        for (int unsigned n = 0; n < N_RANDOM; n++) begin
            pick  = $urandom_range(0, 99);
            first = 16'($urandom_range(0, 2047));
            if (pick < 45) begin
                op = OP_ALLOC;
                case ($urandom_range(0, 19))
                    0:       count = 17'($urandom_range(25, 600));
                    1:       count = 17'($urandom_range(0, 131071));
                    default: count = 17'($urandom_range(1, 24));
                endcase
                first = 16'($urandom);
            end else if (pick < 75) begin
                op    = OP_FREE;
                count = 17'($urandom_range(0, 40));
            end else if (pick < 92) begin
                op    = OP_RESERVE;
                count = 17'($urandom_range(0, 64));
            end else if (pick < 96) begin
                op    = OP_RESERVE;
                first = 16'($urandom);
                count = 17'($urandom_range(0, 131071));
            end else if (pick < 98) begin
                op    = OP_FREE;
                first = 16'($urandom);
                count = 17'($urandom_range(1, 3));
            end else begin
                op    = OP_UNKNOWN;
                first = 16'($urandom);
                count = 17'($urandom_range(0, 131071));
            end
            issue_command(op, first, count, 0, '0, 1'b0);
            if (n < N_RANDOM - N_CALM && $urandom_range(0, 3) == 0)
                idle_burst($urandom_range(1, 13));
        end

        @(negedge i_clk);
        start <= 1'b0;

        // drain, then let the block settle
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_CAP) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("bitmap_page_frame_allocator verification clean");
        end else begin
            $display("bitmap_page_frame_allocator verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
